// ----- sv/skf_pkg.sv -----
package skf_pkg;

	localparam int unsigned Q_W     = 16;
	localparam int unsigned COV_W   = 24;
	localparam int unsigned Z_W     = 16;
	localparam int unsigned X_W     = 32;
	localparam int unsigned K_W     = 16;
	localparam int unsigned CFG_IDX_W = 2;
	localparam int unsigned CFG_W   = 24;

	localparam logic [CFG_IDX_W-1:0] CFG_PROCESS_NOISE      = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_MEASUREMENT_NOISE  = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_INITIAL_COVARIANCE = 2'd2;

	localparam logic [Q_W-1:0]   PROCESS_NOISE_RST      = 16'd66;
	localparam logic [COV_W-1:0] MEASUREMENT_NOISE_RST  = 24'd38011;
	localparam logic [COV_W-1:0] INITIAL_COVARIANCE_RST = 24'd1311;

	localparam int unsigned DIV_STEPS = 16;
	localparam int unsigned DCNT_W    = 4;

	localparam int unsigned PC_W = 4;
	localparam logic [PC_W-1:0] PC_WAIT  = 4'd0;
	localparam logic [PC_W-1:0] PC_PRED  = 4'd1;
	localparam logic [PC_W-1:0] PC_DINIT = 4'd2;
	localparam logic [PC_W-1:0] PC_DIV   = 4'd3;
	localparam logic [PC_W-1:0] PC_DFIN  = 4'd4;
	localparam logic [PC_W-1:0] PC_MLO   = 4'd5;
	localparam logic [PC_W-1:0] PC_MHI   = 4'd6;
	localparam logic [PC_W-1:0] PC_MP    = 4'd7;
	localparam logic [PC_W-1:0] PC_UPD   = 4'd8;
	localparam logic [PC_W-1:0] PC_RST   = 4'd9;

	typedef logic [3:0] op_t;
	localparam op_t OP_WAIT  = 4'd0;
	localparam op_t OP_PRED  = 4'd1;
	localparam op_t OP_DINIT = 4'd2;
	localparam op_t OP_DIV   = 4'd3;
	localparam op_t OP_DFIN  = 4'd4;
	localparam op_t OP_MLO   = 4'd5;
	localparam op_t OP_MHI   = 4'd6;
	localparam op_t OP_MP    = 4'd7;
	localparam op_t OP_UPD   = 4'd8;
	localparam op_t OP_RST   = 4'd9;

	typedef logic [1:0] cond_t;
	localparam cond_t COND_NEXT     = 2'd0;
	localparam cond_t COND_ALWAYS   = 2'd1;
	localparam cond_t COND_RESTART  = 2'd2;
	localparam cond_t COND_DIV_MORE = 2'd3;

	typedef struct packed {
		op_t              op;
		cond_t            cond;
		logic [PC_W-1:0]  target;
	} ctrl_t;

	function automatic ctrl_t ucode(input logic [PC_W-1:0] pc);
		ctrl_t c;
		case (pc)
			PC_WAIT:  c = '{op: OP_WAIT,  cond: COND_RESTART,  target: PC_RST};
			PC_PRED:  c = '{op: OP_PRED,  cond: COND_NEXT,     target: PC_WAIT};
			PC_DINIT: c = '{op: OP_DINIT, cond: COND_NEXT,     target: PC_WAIT};
			PC_DIV:   c = '{op: OP_DIV,   cond: COND_DIV_MORE, target: PC_DIV};
			PC_DFIN:  c = '{op: OP_DFIN,  cond: COND_NEXT,     target: PC_WAIT};
			PC_MLO:   c = '{op: OP_MLO,   cond: COND_NEXT,     target: PC_WAIT};
			PC_MHI:   c = '{op: OP_MHI,   cond: COND_NEXT,     target: PC_WAIT};
			PC_MP:    c = '{op: OP_MP,    cond: COND_NEXT,     target: PC_WAIT};
			PC_UPD:   c = '{op: OP_UPD,   cond: COND_ALWAYS,   target: PC_WAIT};
			PC_RST:   c = '{op: OP_RST,   cond: COND_ALWAYS,   target: PC_WAIT};
			default:  c = '{op: OP_WAIT,  cond: COND_ALWAYS,   target: PC_WAIT};
		endcase
		return c;
	endfunction

endpackage

// ----- sv/skf_in_if.sv -----
interface skf_in_if;
	logic                                 valid;
	logic                                 ready;
	logic                                 action;
	logic signed [skf_pkg::Z_W-1:0]       measurement;

	modport source (output valid, output action, output measurement, input ready);
	modport sink   (input valid, input action, input measurement, output ready);
endinterface

// ----- sv/skf_out_if.sv -----
interface skf_out_if;
	logic                                 valid;
	logic                                 ready;
	logic signed [skf_pkg::X_W-1:0]       estimate;
	logic        [skf_pkg::K_W-1:0]       gain;

	modport source (output valid, output estimate, output gain, input ready);
	modport sink   (input valid, input estimate, input gain, output ready);
endinterface

// ----- sv/scalar_kalman_filter_core.sv -----
// Scalar Kalman filter with a constant state model in fixed point: each word on
// sample either filters a signed 16-bit measurement (action 0) or restarts the
// filter (action 1), and each gives exactly one word on result with the new
// Q16.16 estimate and the Q0.16 gain used. A filter word runs prediction, the
// bit-serial gain divider with setup and fix-up, products and update; a restart
// resets the state. One word is worked on at a time; the next is accepted
// while a finished result still waits in the output register. The user must
// write registers via cfg_we, cfg_index, cfg_wdata only while idle; unchecked.
module scalar_kalman_filter_core (
	input  logic                                 clk,
	input  logic                                 arst_n,
	skf_in_if.sink                               sample,
	skf_out_if.source                            result,
	input  logic                                 cfg_we,
	input  logic [skf_pkg::CFG_IDX_W-1:0]        cfg_index,
	input  logic [skf_pkg::CFG_W-1:0]            cfg_wdata
);

	logic [skf_pkg::Q_W-1:0]   q_noise_q;
	logic [skf_pkg::COV_W-1:0] r_noise_q;
	logic [skf_pkg::COV_W-1:0] p_init_q;

	logic [skf_pkg::PC_W-1:0]   pc_q;
	logic [skf_pkg::DCNT_W-1:0] dcnt_q;
	skf_pkg::ctrl_t             ctrl;

	logic signed [skf_pkg::X_W-1:0] x_q;
	logic [skf_pkg::COV_W-1:0]      p_q;
	logic signed [skf_pkg::Z_W-1:0] z_q;
	logic [skf_pkg::COV_W-1:0]      pp_q;
	logic [skf_pkg::COV_W:0]        denom_q;
	logic [skf_pkg::COV_W:0]        rem_q;
	logic [skf_pkg::K_W-1:0]        k_q;
	logic signed [32:0]             diff_q;
	logic signed [42:0]             prod_q;
	logic signed [34:0]             acc_q;

	logic                           out_valid_q;
	logic signed [skf_pkg::X_W-1:0] out_est_q;
	logic [skf_pkg::K_W-1:0]        out_gain_q;

	logic                           in_fire;
	logic                           out_busy;
	logic                           stall;
	logic                           taken;
	logic                           emit;

	logic [skf_pkg::COV_W:0]        pp_sum;
	logic [skf_pkg::COV_W-1:0]      pp_sat;
	logic signed [32:0]             diff_new;
	logic [skf_pkg::COV_W+1:0]      rem_sh;
	logic [skf_pkg::COV_W+1:0]      rem_sub;
	logic signed [17:0]             mul_a;
	logic signed [24:0]             mul_b;
	logic signed [42:0]             mul_p;
	logic signed [34:0]             x_sum;
	logic signed [skf_pkg::X_W-1:0] x_new;

	assign ctrl     = skf_pkg::ucode(pc_q);
	assign in_fire  = sample.valid && sample.ready;
	assign out_busy = out_valid_q && !result.ready;
	assign sample.ready = (ctrl.op == skf_pkg::OP_WAIT);

	assign result.valid    = out_valid_q;
	assign result.estimate = out_est_q;
	assign result.gain     = out_gain_q;

	assign emit  = ((ctrl.op == skf_pkg::OP_UPD) || (ctrl.op == skf_pkg::OP_RST)) && !out_busy;
	assign stall = ((ctrl.op == skf_pkg::OP_WAIT) && !in_fire) ||
		(((ctrl.op == skf_pkg::OP_UPD) || (ctrl.op == skf_pkg::OP_RST)) && out_busy);

	always_comb begin
		case (ctrl.cond)
			skf_pkg::COND_NEXT:     taken = 1'b0;
			skf_pkg::COND_ALWAYS:   taken = 1'b1;
			skf_pkg::COND_RESTART:  taken = sample.action;
			skf_pkg::COND_DIV_MORE: taken = (dcnt_q != skf_pkg::DCNT_W'(skf_pkg::DIV_STEPS - 1));
			default:                taken = 1'b0;
		endcase
	end

	assign pp_sum = {1'b0, p_q} + {9'b0, q_noise_q};
	assign pp_sat = pp_sum[skf_pkg::COV_W] ? {skf_pkg::COV_W{1'b1}} : pp_sum[skf_pkg::COV_W-1:0];
	assign diff_new = {z_q[skf_pkg::Z_W-1], z_q, 16'b0} - {x_q[skf_pkg::X_W-1], x_q};

	assign rem_sh  = {rem_q, 1'b0};
	assign rem_sub = rem_sh - {1'b0, denom_q};

	always_comb begin
		case (ctrl.op)
			skf_pkg::OP_MLO: begin
				mul_a = {2'b0, k_q};
				mul_b = {9'b0, diff_q[15:0]};
			end
			skf_pkg::OP_MHI: begin
				mul_a = {2'b0, k_q};
				mul_b = {{8{diff_q[32]}}, diff_q[32:16]};
			end
			skf_pkg::OP_MP: begin
				mul_a = 18'sd65536 - {2'b0, k_q};
				mul_b = {1'b0, pp_q};
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
	end

	assign mul_p = 43'(mul_a) * 43'(mul_b);

	assign x_sum = acc_q + {{3{x_q[skf_pkg::X_W-1]}}, x_q};
	always_comb begin
		if (x_sum > 35'sd2147483647) begin
			x_new = 32'sh7FFFFFFF;
		end else if (x_sum < -35'sd2147483648) begin
			x_new = 32'sh80000000;
		end else begin
			x_new = x_sum[31:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			q_noise_q <= skf_pkg::PROCESS_NOISE_RST;
			r_noise_q <= skf_pkg::MEASUREMENT_NOISE_RST;
			p_init_q  <= skf_pkg::INITIAL_COVARIANCE_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				skf_pkg::CFG_PROCESS_NOISE:      q_noise_q <= cfg_wdata[skf_pkg::Q_W-1:0];
				skf_pkg::CFG_MEASUREMENT_NOISE:  r_noise_q <= cfg_wdata;
				skf_pkg::CFG_INITIAL_COVARIANCE: p_init_q  <= cfg_wdata;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pc_q <= skf_pkg::PC_WAIT;
		end else if (!stall) begin
			pc_q <= taken ? ctrl.target : pc_q + 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (emit) begin
			out_valid_q <= 1'b1;
		end else if (result.valid && result.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			x_q         <= '0;
			p_q         <= skf_pkg::INITIAL_COVARIANCE_RST;
			dcnt_q      <= '0;
		end else begin
			case (ctrl.op)
				skf_pkg::OP_DINIT: dcnt_q <= '0;
				skf_pkg::OP_DIV:   dcnt_q <= dcnt_q + 1'b1;
				skf_pkg::OP_UPD: begin
					if (emit) begin
						x_q         <= x_new;
						p_q         <= prod_q[39:16];
					end
				end
				skf_pkg::OP_RST: begin
					if (emit) begin
						x_q         <= '0;
						p_q         <= p_init_q;
					end
				end
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (ctrl.op)
			skf_pkg::OP_WAIT: begin
				if (in_fire) begin
					z_q <= sample.measurement;
				end
			end
			skf_pkg::OP_PRED: begin
				pp_q   <= pp_sat;
				diff_q <= diff_new;
			end
			skf_pkg::OP_DINIT: begin
				rem_q   <= {1'b0, pp_q};
				denom_q <= {1'b0, pp_q} + {1'b0, r_noise_q};
				k_q     <= '0;
			end
			skf_pkg::OP_DIV: begin
				if (!rem_sub[skf_pkg::COV_W+1]) begin
					rem_q <= rem_sub[skf_pkg::COV_W:0];
					k_q   <= {k_q[skf_pkg::K_W-2:0], 1'b1};
				end else begin
					rem_q <= rem_sh[skf_pkg::COV_W:0];
					k_q   <= {k_q[skf_pkg::K_W-2:0], 1'b0};
				end
			end
			skf_pkg::OP_DFIN: begin
				if (denom_q == '0) begin
					k_q <= '0;
				end else if (r_noise_q == '0) begin
					k_q <= {skf_pkg::K_W{1'b1}};
				end
			end
			skf_pkg::OP_MLO: prod_q <= mul_p;
			skf_pkg::OP_MHI: begin
				acc_q  <= {{8{prod_q[42]}}, prod_q[42:16]};
				prod_q <= mul_p;
			end
			skf_pkg::OP_MP: begin
				acc_q  <= acc_q + prod_q[34:0];
				prod_q <= mul_p;
			end
			skf_pkg::OP_UPD: begin
				if (emit) begin
					out_est_q  <= x_new;
					out_gain_q <= k_q;
				end
			end
			skf_pkg::OP_RST: begin
				if (emit) begin
					out_est_q  <= '0;
					out_gain_q <= '0;
				end
			end
			default: ;
		endcase
	end

endmodule
